// ===== hdl/time_window_shortest_path_defines.svh =====
// ----------------------------------------------------------------------------
// time_window_shortest_path_defines
// assertion macros for the time window shortest path block
// ----------------------------------------------------------------------------
`ifndef TIME_WINDOW_SHORTEST_PATH_DEFINES_SVH
`define TIME_WINDOW_SHORTEST_PATH_DEFINES_SVH

`ifndef SYNTHESIS
`define TWSP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define TWSP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define TWSP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TWSP_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== hdl/twsp_pkg.sv =====
// ----------------------------------------------------------------------------
// twsp_pkg
// shared widths, constants and control structs
// ----------------------------------------------------------------------------
package twsp_pkg;

  localparam int NODE_W = 8;
  localparam int TIME_W = 30;
  localparam int ARR_W  = 31;
  localparam int CNT_W  = 9;

  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_EDGES_DEF = 1024;

  localparam logic [ARR_W-1:0] T_INF          = {ARR_W{1'b1}};
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(256);

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [TIME_W-1:0] window_start;
    logic [TIME_W-1:0] window_end;
  } edge_t;

  typedef struct packed {
    logic store_edge;
    logic job_init;
    logic scan_clr;
    logic scan_issue;
    logic settle;
    logic edge_issue;
    logic edge_eval;
    logic edge_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic pick_goal;
    logic edge_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/twsp_in_if.sv =====
// ----------------------------------------------------------------------------
// twsp_in_if
// edge request channel
// ----------------------------------------------------------------------------
interface twsp_in_if;
  logic                      valid;
  logic                      ready;
  logic [twsp_pkg::NODE_W-1:0] src_node;
  logic [twsp_pkg::NODE_W-1:0] dst_node;
  logic [twsp_pkg::TIME_W-1:0] window_start;
  logic [twsp_pkg::TIME_W-1:0] window_end;
  logic                      last_edge;

  modport source (output valid, src_node, dst_node, window_start, window_end, last_edge,
                  input ready);
  modport sink   (input valid, src_node, dst_node, window_start, window_end, last_edge,
                  output ready);
endinterface

// ===== hdl/twsp_out_if.sv =====
// ----------------------------------------------------------------------------
// twsp_out_if
// result request channel
// ----------------------------------------------------------------------------
interface twsp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       reached;
  logic [twsp_pkg::ARR_W-1:0] min_time;

  modport source (output valid, reached, min_time, input ready);
  modport sink   (input valid, reached, min_time, output ready);
endinterface

// ===== hdl/time_window_shortest_path.sv =====
// ----------------------------------------------------------------------------
// time_window_shortest_path
// earliest arrival search over directed edges with time windows
// ----------------------------------------------------------------------------
// in_ch carries one edge request per cycle; edges load at one per cycle
// while the block is loading. The request with last_edge set is stored
// and starts the search from node 0 at time 0; in_ch.ready stays low
// until the result has entered the output register.
// Search: after init, each round scans the best-time table and, unless
// done, relaxes every stored edge through read, evaluate and update
// states, an order set by the single read port of the edge store and of
// the best-time table. The job runs init, one round per settled node, a
// last scan and the load of the result.
// out_ch gives reached and min_time; the result waits in its register
// while the receiver stalls; new edges still load, and the next result
// waits in the controller until the register is free.
// cfg_we writes node_count; only the user keeps it to when the block is idle.
// Reset clears the edge count, the valid and settled marks, the output
// register, and sets node_count to 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
module time_window_shortest_path #(
  parameter int MAX_NODES = twsp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = twsp_pkg::MAX_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [twsp_pkg::CNT_W-1:0] cfg_wdata,
  twsp_in_if.sink                    in_ch,
  twsp_out_if.source                 out_ch
);
  import twsp_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  edge_t in_edge;

  assign in_edge.src_node     = in_ch.src_node;
  assign in_edge.dst_node     = in_ch.dst_node;
  assign in_edge.window_start = in_ch.window_start;
  assign in_edge.window_end   = in_ch.window_end;

  twsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_edge),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  twsp_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_edge      (in_edge),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_reached  (out_ch.reached),
    .out_min_time (out_ch.min_time)
  );

endmodule

// ===== hdl/twsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// twsp_ctrl
// sequencer for edge loading, best-time scans and edge relaxation
// ----------------------------------------------------------------------------
module twsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  twsp_pkg::sts_t sts,
  output twsp_pkg::cmd_t cmd
);
  import twsp_pkg::*;

  localparam logic [3:0] ST_LOAD     = 4'd0;
  localparam logic [3:0] ST_INIT     = 4'd1;
  localparam logic [3:0] ST_SCAN     = 4'd2;
  localparam logic [3:0] ST_SCAN_END = 4'd3;
  localparam logic [3:0] ST_DECIDE   = 4'd4;
  localparam logic [3:0] ST_EDGE_RD  = 4'd5;
  localparam logic [3:0] ST_EDGE_EV  = 4'd6;
  localparam logic [3:0] ST_EDGE_WR  = 4'd7;
  localparam logic [3:0] ST_OUT      = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready       = 1'b1;
        cmd.store_edge = in_valid;
        if (in_valid && in_last) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.job_init = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.found || sts.pick_goal) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.settle = 1'b1;
          state_nxt  = ST_EDGE_RD;
        end
      end
      ST_EDGE_RD: begin
        if (sts.edge_done) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end else begin
          cmd.edge_issue = 1'b1;
          state_nxt      = ST_EDGE_EV;
        end
      end
      ST_EDGE_EV: begin
        cmd.edge_eval = 1'b1;
        state_nxt     = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        cmd.edge_upd = 1'b1;
        state_nxt    = ST_EDGE_RD;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/twsp_dp.sv =====
// ----------------------------------------------------------------------------
// twsp_dp
// edge store, best-time table, settled marks, scan and relax datapath
// ----------------------------------------------------------------------------
`include "time_window_shortest_path_defines.svh"

module twsp_dp #(
  parameter int MAX_NODES = twsp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = twsp_pkg::MAX_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [twsp_pkg::CNT_W-1:0] cfg_wdata,
  input  twsp_pkg::edge_t            in_edge,
  input  twsp_pkg::cmd_t             cmd,
  output twsp_pkg::sts_t             sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_reached,
  output logic [twsp_pkg::ARR_W-1:0] out_min_time
);
  import twsp_pkg::*;

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW0   = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CW0 > CNT_W) ? CW0 : CNT_W;
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [CNT_W-1:0] node_count_r;
  logic [CMP_W-1:0] nodes_r, nodes_eff, goal;

  edge_t            edge_mem [MAX_EDGES];
  edge_t            edge_q_r;
  logic [ECW-1:0]   edges_r, edge_idx_r;
  logic             room;

  logic [ARR_W-1:0] best_mem [MAX_NODES];
  logic [ARR_W-1:0] best_q_r;
  logic [NW-1:0]    best_ra, best_wa;
  logic [ARR_W-1:0] best_wd;
  logic             best_we;
  logic [MAX_NODES-1:0] valid_r, settled_r;

  logic [NW-1:0]    scan_idx_r, eval_idx_r, pick_r;
  logic             pend_r;
  logic [ARR_W-1:0] pick_t_r, scan_cur;

  logic [ARR_W-1:0] now_r;
  logic [CMP_W-1:0] s_ext, d_ext;
  logic [ARR_W-1:0] open_ext, close_ext, dep_t;
  logic             take, take_r, upd_hit;
  logic [ARR_W-1:0] t_r, cur_d;
  logic [NW-1:0]    d_r;

  // node count in effect
  always_comb begin
    if (node_count_r == '0) begin
      nodes_eff = CMP_W'(1);
    end else if (CMP_W'(node_count_r) > CMP_W'(MAX_NODES)) begin
      nodes_eff = CMP_W'(MAX_NODES);
    end else begin
      nodes_eff = CMP_W'(node_count_r);
    end
  end
  assign goal = nodes_r - CMP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.job_init) nodes_r <= nodes_eff;
  end

  // edge store
  assign room = edges_r < ECW'(MAX_EDGES);

  always_ff @(posedge clk) begin
    if (cmd.store_edge && room) edge_mem[edges_r[EAW-1:0]] <= in_edge;
    if (cmd.edge_issue) edge_q_r <= edge_mem[edge_idx_r[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      edges_r <= '0;
    end else if (cmd.store_edge && room) begin
      edges_r <= edges_r + ECW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.settle) begin
      edge_idx_r <= '0;
    end else if (cmd.edge_issue) begin
      edge_idx_r <= edge_idx_r + ECW'(1);
    end
  end

  // relax one edge
  assign s_ext     = CMP_W'(edge_q_r.src_node);
  assign d_ext     = CMP_W'(edge_q_r.dst_node);
  assign open_ext  = ARR_W'(edge_q_r.window_start);
  assign close_ext = ARR_W'(edge_q_r.window_end);
  assign dep_t     = (open_ext > now_r) ? open_ext : now_r;
  assign take      = (s_ext == CMP_W'(pick_r)) && (d_ext < nodes_r) && (close_ext >= now_r);

  always_ff @(posedge clk) begin
    if (cmd.edge_eval) begin
      take_r <= take;
      t_r    <= dep_t + ARR_W'(1);
      d_r    <= d_ext[NW-1:0];
    end
  end

  assign cur_d   = valid_r[d_r] ? best_q_r : T_INF;
  assign upd_hit = cmd.edge_upd && take_r && (t_r < cur_d);

  // best-time table
  assign best_ra = cmd.edge_eval ? d_ext[NW-1:0] : scan_idx_r;
  assign best_we = cmd.job_init || upd_hit;
  assign best_wa = cmd.job_init ? '0 : d_r;
  assign best_wd = cmd.job_init ? '0 : t_r;

  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_wa] <= best_wd;
    best_q_r <= best_mem[best_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      valid_r   <= '0;
      settled_r <= '0;
    end else begin
      if (cmd.job_init) valid_r[0] <= 1'b1;
      if (upd_hit) valid_r[d_r] <= 1'b1;
      if (cmd.settle) settled_r[pick_r] <= 1'b1;
    end
  end

  // minimum scan
  assign scan_cur = valid_r[eval_idx_r] ? best_q_r : T_INF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx_r <= '0;
      pick_t_r   <= T_INF;
    end else begin
      if (cmd.scan_issue) begin
        eval_idx_r <= scan_idx_r;
        scan_idx_r <= scan_idx_r + NW'(1);
      end
      if (pend_r && !settled_r[eval_idx_r] && (scan_cur < pick_t_r)) begin
        pick_t_r <= scan_cur;
        pick_r   <= eval_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.settle) now_r <= pick_t_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_reached  <= sts.found;
      out_min_time <= sts.found ? pick_t_r : '0;
    end
  end

  assign sts.scan_last = CMP_W'(scan_idx_r) == goal;
  assign sts.found     = pick_t_r != T_INF;
  assign sts.pick_goal = CMP_W'(pick_r) == goal;
  assign sts.edge_done = edge_idx_r == edges_r;
  assign sts.out_free  = !out_valid || out_ready;

  `TWSP_ASSERT(a_edges_cap, clk, rst_n, edges_r <= ECW'(MAX_EDGES), "edge count past store size")
  `TWSP_ASSERT(a_job_clear, clk, rst_n, cmd.out_load |=> (edges_r == '0 && valid_r == '0), "job state not cleared")
  `TWSP_ASSERT(a_settle_once, clk, rst_n, cmd.settle |-> !settled_r[pick_r], "node settled twice")

endmodule
